FILE: design/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg: shared types and constants for the byte text encoder
// Holds the format codes, the character tables and the job record that
// travels from the front end to the back end through the job queue.
// ----------------------------------------------------------------------------
package bte_pkg;

   // Output format codes, as written in the format register
   localparam logic [1:0] FMT_RAW = 2'd0;
   localparam logic [1:0] FMT_HEX = 2'd1;
   localparam logic [1:0] FMT_B64 = 2'd2;

   // Character tables, entry 0 in the leftmost position
   localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [0:15][7:0] HEX_DIGITS = "0123456789abcdef";
   localparam logic [7:0]       PAD_CHAR   = 8'h3D;

   // One encoded job: up to four characters, emitted from index 0 upward
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;  // index of the final character of the job
      logic            last;      // job ends the message
   } job_type;

endpackage

FILE: design/bte_if.sv
// ----------------------------------------------------------------------------
// bte_if: request and response channel interfaces
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: design/byte_text_encoder_base64_hex.sv
// ----------------------------------------------------------------------------
// byte_text_encoder_base64_hex: byte stream to raw, hex or base64 text
// Top level joining the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one message byte per request with a last-of-message flag.
//   rsp_if carries one output character per item; last_char marks the final
//   character of a message. csr_write_enable/csr_write_data set the format
//   (0 raw, 1 hex, 2 base64 with padding, 3 acts as raw); write it only idle.
// Path: a taken request is written into the job queue, and the back end
//   then loads its first character from the queue head into the output
//   register. A base64 byte that only fills the group gives nothing.
// Throughput: one character per cycle, set by the single output register,
//   while rsp_if is ready. Raw: 1 char per byte, hex 2, base64 4 per 3 bytes.
// The front end keeps taking requests while the job queue has room, so a
//   stalled receiver holds the output register, then fills the queue, and
//   only then drops req_if.ready. Nothing is lost or repeated under stall.
// Reset (synchronous, active high) empties the queue and the output
//   register, drops any held base64 bytes and sets the format to raw.
// ----------------------------------------------------------------------------
module byte_text_encoder_base64_hex #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   bte_req_if.sink    req_if,
   bte_rsp_if.source  rsp_if
);

   logic             queue_full;
   logic             job_push;
   logic             job_pop;
   logic             head_valid;
   bte_pkg::job_type push_job;
   bte_pkg::job_type head_job;

   bte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_data_byte    (req_if.data_byte),
      .req_last_byte    (req_if.last_byte),
      .queue_full       (queue_full),
      .job_push         (job_push),
      .job              (push_job)
   );

   bte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (job_pop),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_out_char  (rsp_if.out_char),
      .rsp_last_char (rsp_if.last_char)
   );

endmodule

FILE: design/bte_front.sv
// ----------------------------------------------------------------------------
// bte_front: request intake and classification
// Holds the format register and the base64 byte group, and turns each
// request that completes some output into a job of up to four characters.
// ----------------------------------------------------------------------------
module bte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_write_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             queue_full,
   output logic             job_push,
   output bte_pkg::job_type job
);

   logic [1:0]  format_ff, format_in;
   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;
   logic        is_b64;
   logic [23:0] group;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_b64    = (format_ff == bte_pkg::FMT_B64);
   assign job_push  = accept && (!is_b64 || held_count_ff == 2'd2 || req_last_byte);

   // Assemble the 24-bit base64 group, zero filled for short groups
   always_comb begin
      case (held_count_ff)
         2'd0:    group = {req_data_byte, 16'h0000};
         2'd1:    group = {held_bytes_ff[15:8], req_data_byte, 8'h00};
         default: group = {held_bytes_ff, req_data_byte};
      endcase
   end

   // Build the job for the current request
   always_comb begin
      job.chars    = {4{req_data_byte}};
      job.last_idx = 2'd0;
      job.last     = req_last_byte;
      case (format_ff)
         bte_pkg::FMT_HEX: begin
            job.chars[0] = bte_pkg::HEX_DIGITS[req_data_byte[7:4]];
            job.chars[1] = bte_pkg::HEX_DIGITS[req_data_byte[3:0]];
            job.last_idx = 2'd1;
         end
         bte_pkg::FMT_B64: begin
            job.chars[0] = bte_pkg::B64_ALPHABET[group[23:18]];
            job.chars[1] = bte_pkg::B64_ALPHABET[group[17:12]];
            job.chars[2] = (held_count_ff != 2'd0) ?
                           bte_pkg::B64_ALPHABET[group[11:6]] : bte_pkg::PAD_CHAR;
            job.chars[3] = (held_count_ff == 2'd2) ?
                           bte_pkg::B64_ALPHABET[group[5:0]] : bte_pkg::PAD_CHAR;
            job.last_idx = 2'd3;
         end
         default: begin
            job.chars[0] = req_data_byte;
         end
      endcase
   end

   // Update the held group: drop on any emitted job, else append the byte
   always_comb begin
      format_in     = csr_write_enable ? csr_write_data : format_ff;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      if (accept) begin
         if (job_push) begin
            held_bytes_in = 16'h0000;
            held_count_in = 2'd0;
         end else begin
            held_bytes_in = (held_count_ff == 2'd0) ? {req_data_byte, 8'h00}
                                                    : {held_bytes_ff[15:8], req_data_byte};
            held_count_in = held_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= bte_pkg::FMT_RAW;
         held_bytes_ff <= 16'h0000;
         held_count_ff <= 2'd0;
      end else begin
         format_ff     <= format_in;
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

FILE: design/bte_queue.sv
// ----------------------------------------------------------------------------
// bte_queue: job queue between front end and back end
// Small FIFO of encoded jobs; the head is visible while not empty.
// ----------------------------------------------------------------------------
module bte_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bte_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output bte_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bte_pkg::job_type    slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store job payload
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/bte_back.sv
// ----------------------------------------------------------------------------
// bte_back: character sequencer and output register
// Walks the head job one character per cycle into the response register
// while it is empty or taken; pops the job when its final character is loaded.
// ----------------------------------------------------------------------------
module bte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bte_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = head_valid && (!valid_ff || rsp_ready);
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && at_end;

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   // Load next character, or drain the register when taken
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = head_job.chars[idx_ff];
         last_in  = head_job.last && at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule
